@@ rtl/tdpt_pkg.sv @@
package tdpt_pkg;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture the request word, set divisor to two
      logic start;     // begin a remainder pass with the current divisor
      logic step;      // one restoring division bit
      logic advance;   // move to the next divisor
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic below_two;   // candidate negative, zero or one
      logic last;        // final division bit is being taken this cycle
      logic bound_fail;  // divisor exceeds quotient: no divisor left to try
      logic rem_zero;    // remainder of the last pass is zero
   } status_type;

   // First divisor tried
   localparam int FIRST_DIVISOR = 2;

endpackage

@@ rtl/tdpt_ctrl.sv @@
module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_prime,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DIVIDE,
      DECIDE,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      is_prime_ff, is_prime_in;

   // Sequence one word through load, remainder passes and answer
   always_comb begin
      state_in    = state_ff;
      is_prime_in = is_prime_ff;
      cmd         = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.below_two) begin
               is_prime_in = 1'b0;
               state_in    = DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = DIVIDE;
            end
         end
         DIVIDE: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            if (status.bound_fail) begin
               is_prime_in = 1'b1;
               state_in    = DONE;
            end else if (status.rem_zero) begin
               is_prime_in = 1'b0;
               state_in    = DONE;
            end else begin
               cmd.advance = 1'b1;
               cmd.start   = 1'b1;
               state_in    = DIVIDE;
            end
         end
         DONE: begin
            if (!rsp_stall) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and the answer bit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         is_prime_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         is_prime_ff <= is_prime_in;
      end
   end

   assign req_stall    = (state_ff != IDLE);
   assign rsp_valid    = (state_ff == DONE);
   assign rsp_is_prime = is_prime_ff;

endmodule

@@ rtl/tdpt_datapath.sv @@
module tdpt_datapath
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic signed [31:0] candidate,
   input  cmd_type            cmd,
   output status_type         status
);

   localparam int MagW = VALUE_WIDTH - 1;
   localparam int DivW = VALUE_WIDTH / 2 + 1;
   localparam int CntW = $clog2(MagW);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [DivW-1:0]        divisor_ff;
   logic [MagW-1:0]        quot_ff;
   logic [DivW-1:0]        rem_ff;
   logic [CntW-1:0]        count_ff;

   logic [MagW-1:0]        magnitude;
   logic [DivW:0]          trial;
   logic [DivW:0]          divisor_ext;
   logic [DivW:0]          diff;
   logic                   fits;

   assign magnitude = value_ff[MagW-1:0];

   // One restoring division bit: shift in the next dividend bit, subtract when it fits
   assign trial       = {rem_ff, quot_ff[MagW-1]};
   assign divisor_ext = {1'b0, divisor_ff};
   assign fits        = (trial >= divisor_ext);
   assign diff        = trial - divisor_ext;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff   <= VALUE_WIDTH'(candidate);
         divisor_ff <= DivW'(FIRST_DIVISOR);
      end else if (cmd.advance) begin
         divisor_ff <= divisor_ff + 1'b1;
      end

      if (cmd.start) begin
         quot_ff  <= magnitude;
         rem_ff   <= '0;
         count_ff <= CntW'(MagW - 1);
      end else if (cmd.step) begin
         quot_ff  <= {quot_ff[MagW-2:0], fits};
         rem_ff   <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
         count_ff <= count_ff - 1'b1;
      end
   end

   // Report range, pass progress and pass outcome
   assign status.below_two  = value_ff[VALUE_WIDTH-1] || (magnitude < MagW'(FIRST_DIVISOR));
   assign status.last       = (count_ff == '0);
   assign status.bound_fail = (MagW'(divisor_ff) > quot_ff);
   assign status.rem_zero   = (rem_ff == '0);

endmodule

@@ rtl/trial_division_prime_test_core.sv @@
// Candidates below two (negatives included) are answered from the check state;
// otherwise each divisor tried runs a pass of the bit-serial remainder unit
// (one restoring step per magnitude bit) and then a decide state.
// Throughput: one word at a time; the next request word is taken after the result leaves.
// Reset: synchronous, active high; returns the controller to idle with no result pending.
module trial_division_prime_test_core
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_candidate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_prime
);

   cmd_type    cmd;
   status_type status;

   // Sequence the trial divisions
   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   // Hold the candidate, divisor and remainder unit
   tdpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
